@@ rtl/pwmp_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmp_pkg
// Shared types and codes for the peer-wire message parser.
// ----------------------------------------------------------------------------
package pwmp_pkg;

  // parse phases
  localparam logic [3:0] PH_HS_LEN      = 4'd0;
  localparam logic [3:0] PH_HS_PROTO    = 4'd1;
  localparam logic [3:0] PH_HS_RESERVED = 4'd2;
  localparam logic [3:0] PH_HS_INFO     = 4'd3;
  localparam logic [3:0] PH_HS_PEER     = 4'd4;
  localparam logic [3:0] PH_LEN         = 4'd5;
  localparam logic [3:0] PH_ID          = 4'd6;
  localparam logic [3:0] PH_REQ         = 4'd7;
  localparam logic [3:0] PH_PHDR        = 4'd8;
  localparam logic [3:0] PH_PDATA       = 4'd9;
  localparam logic [3:0] PH_BITF        = 4'd10;
  localparam logic [3:0] PH_HALT        = 4'd11;

  // result kinds
  localparam logic [3:0] KIND_INFOHASH    = 4'd0;
  localparam logic [3:0] KIND_PEER_ID     = 4'd1;
  localparam logic [3:0] KIND_REQUEST     = 4'd2;
  localparam logic [3:0] KIND_PIECE_HDR   = 4'd3;
  localparam logic [3:0] KIND_PIECE_DATA  = 4'd4;
  localparam logic [3:0] KIND_BITFIELD    = 4'd5;
  localparam logic [3:0] KIND_KEEPALIVE   = 4'd6;
  localparam logic [3:0] KIND_BAD_PSTRLEN = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN_ID  = 4'd8;
  localparam logic [3:0] KIND_SHORT_PIECE = 4'd9;

  // message ids and sizes
  localparam logic [7:0]  ID_BITFIELD    = 8'd5;
  localparam logic [7:0]  ID_REQUEST     = 8'd6;
  localparam logic [7:0]  ID_PIECE       = 8'd7;
  localparam logic [7:0]  PSTRLEN        = 8'd19;
  localparam logic [31:0] PIECE_OVERHEAD = 32'd9;
  localparam logic [31:0] BITF_OVERHEAD  = 32'd1;
  localparam logic [31:0] PROTO_LAST     = 32'd18;
  localparam logic [31:0] RESERVED_LAST  = 32'd7;
  localparam logic [31:0] ID_LAST        = 32'd19;
  localparam logic [31:0] LEN_LAST       = 32'd3;
  localparam logic [31:0] REQ_LAST       = 32'd11;
  localparam logic [31:0] PHDR_LAST      = 32'd7;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [34:0] flag_base;
    logic [7:0]  bit_flags;
    logic [31:0] block_length;
    logic [31:0] block_begin;
    logic [31:0] piece_index;
    logic [7:0]  data_byte;
    logic [4:0]  hs_position;
    logic        last;
  } res_t;

endpackage

@@ rtl/peer_wire_message_parser.sv @@
// ----------------------------------------------------------------------------
// peer_wire_message_parser
// Parses a peer-wire byte stream: handshake check, then message deframing.
// ----------------------------------------------------------------------------
// A result passes from the input register through the core into the result
// register before it is presented on the master side. Throughput: one byte
// per cycle while the result side has room, set by the single-pass core
// between the input register and the result register with skid entry.
// Reset (rst, synchronous) returns to the handshake length byte and clears
// all counters and accumulators; an error halts parsing until reset.
module peer_wire_message_parser
  import pwmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_value
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // hs_position[4:0], data_byte[12:5],
                                  // piece_index[44:13], block_begin[76:45],
                                  // block_length[108:77], bit_flags[116:109],
                                  // flag_base[151:117]
  output logic [3:0]   m_tuser,   // kind
  output logic         m_tlast    // last
);

  byte_item_t item;
  res_t       res;
  logic       res_valid;
  logic       out_ready;
  logic       take;

  // advance the held byte whenever the result side has room
  assign take = item.valid && out_ready;

  pwmp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  pwmp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (item.value),
    .res_valid (res_valid),
    .res       (res)
  );

  pwmp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ rtl/pwmp_in_reg.sv @@
// ----------------------------------------------------------------------------
// pwmp_in_reg
// Input register holding one received byte for the parser core.
// ----------------------------------------------------------------------------
module pwmp_in_reg
  import pwmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value[7:0]
  input  logic        take,
  output byte_item_t  item
);

  logic       in_valid;
  logic [7:0] in_byte;

  assign s_tready   = !in_valid || take;
  assign item.valid = in_valid;
  assign item.value = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

@@ rtl/pwmp_core.sv @@
// ----------------------------------------------------------------------------
// pwmp_core
// Per-byte parse state and result generation for handshake and messages.
// ----------------------------------------------------------------------------
module pwmp_core
  import pwmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [3:0]  phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] index_accum, index_accum_next;
  logic [31:0] begin_accum, begin_accum_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] limit, limit_next;
  logic [31:0] cnt_inc;
  logic [31:0] frame_shift;

  assign cnt_inc     = byte_count + 32'd1;
  assign frame_shift = {frame_length[23:0], in_byte};

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    index_accum_next  = index_accum;
    begin_accum_next  = begin_accum;
    length_accum_next = length_accum;
    limit_next        = limit;
    res_valid         = 1'b0;
    res               = '0;

    case (phase)
      PH_HS_LEN: begin
        if (in_byte != PSTRLEN) begin
          res_valid     = 1'b1;
          res.kind      = KIND_BAD_PSTRLEN;
          res.data_byte = in_byte;
          res.last      = 1'b1;
          phase_next    = PH_HALT;
        end else begin
          phase_next      = PH_HS_PROTO;
          byte_count_next = '0;
        end
      end
      PH_HS_PROTO: begin
        byte_count_next = cnt_inc;
        if (byte_count == PROTO_LAST) begin
          phase_next      = PH_HS_RESERVED;
          byte_count_next = '0;
        end
      end
      PH_HS_RESERVED: begin
        byte_count_next = cnt_inc;
        if (byte_count == RESERVED_LAST) begin
          phase_next      = PH_HS_INFO;
          byte_count_next = '0;
        end
      end
      PH_HS_INFO, PH_HS_PEER: begin
        res_valid       = 1'b1;
        res.kind        = (phase == PH_HS_INFO) ? KIND_INFOHASH : KIND_PEER_ID;
        res.hs_position = byte_count[4:0];
        res.data_byte   = in_byte;
        byte_count_next = cnt_inc;
        if (byte_count == ID_LAST) begin
          byte_count_next = '0;
          if (phase == PH_HS_INFO) begin
            phase_next = PH_HS_PEER;
          end else begin
            res.last   = 1'b1;
            phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        frame_length_next = frame_shift;
        byte_count_next   = cnt_inc;
        if (byte_count == LEN_LAST) begin
          byte_count_next = '0;
          if (frame_shift == '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_KEEPALIVE;
            res.last  = 1'b1;
          end else begin
            phase_next = PH_ID;
          end
        end
      end
      PH_ID: begin
        byte_count_next = '0;
        // remaining payload count, shared by piece and bitfield
        limit_next = frame_length -
                     ((in_byte == ID_PIECE) ? PIECE_OVERHEAD : BITF_OVERHEAD);
        if (in_byte == ID_REQUEST) begin
          phase_next = PH_REQ;
        end else if (in_byte == ID_PIECE) begin
          if (frame_length < PIECE_OVERHEAD) begin
            res_valid     = 1'b1;
            res.kind      = KIND_SHORT_PIECE;
            res.data_byte = in_byte;
            res.last      = 1'b1;
            phase_next    = PH_HALT;
          end else begin
            phase_next = PH_PHDR;
          end
        end else if (in_byte == ID_BITFIELD) begin
          phase_next = (frame_length == BITF_OVERHEAD) ? PH_LEN : PH_BITF;
        end else begin
          res_valid     = 1'b1;
          res.kind      = KIND_UNKNOWN_ID;
          res.data_byte = in_byte;
          res.last      = 1'b1;
          phase_next    = PH_HALT;
        end
      end
      PH_REQ, PH_PHDR: begin
        case (byte_count[3:2])
          2'd0:    index_accum_next  = {index_accum[23:0], in_byte};
          2'd1:    begin_accum_next  = {begin_accum[23:0], in_byte};
          default: length_accum_next = {length_accum[23:0], in_byte};
        endcase
        byte_count_next = cnt_inc;
        if (phase == PH_REQ && byte_count == REQ_LAST) begin
          res_valid        = 1'b1;
          res.kind         = KIND_REQUEST;
          res.piece_index  = index_accum;
          res.block_begin  = begin_accum;
          res.block_length = {length_accum[23:0], in_byte};
          res.last         = 1'b1;
          byte_count_next  = '0;
          phase_next       = PH_LEN;
        end else if (phase == PH_PHDR && byte_count == PHDR_LAST) begin
          res_valid        = 1'b1;
          res.kind         = KIND_PIECE_HDR;
          res.piece_index  = index_accum;
          res.block_begin  = {begin_accum[23:0], in_byte};
          res.block_length = limit;
          byte_count_next  = '0;
          if (limit == '0) begin
            res.last   = 1'b1;
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_PDATA;
          end
        end
      end
      PH_PDATA: begin
        res_valid       = 1'b1;
        res.kind        = KIND_PIECE_DATA;
        res.data_byte   = in_byte;
        byte_count_next = cnt_inc;
        if (cnt_inc == limit) begin
          res.last        = 1'b1;
          byte_count_next = '0;
          phase_next      = PH_LEN;
        end
      end
      PH_BITF: begin
        res_valid       = 1'b1;
        res.kind        = KIND_BITFIELD;
        res.bit_flags   = in_byte;
        res.flag_base   = {byte_count, 3'b000};
        byte_count_next = cnt_inc;
        if (cnt_inc == limit) begin
          res.last        = 1'b1;
          byte_count_next = '0;
          phase_next      = PH_LEN;
        end
      end
      default: begin
        // halted: drop every byte until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HS_LEN;
      byte_count   <= '0;
      frame_length <= '0;
      index_accum  <= '0;
      begin_accum  <= '0;
      length_accum <= '0;
      limit        <= '0;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      index_accum  <= index_accum_next;
      begin_accum  <= begin_accum_next;
      length_accum <= length_accum_next;
      limit        <= limit_next;
    end
  end

endmodule

@@ rtl/pwmp_out_reg.sv @@
// ----------------------------------------------------------------------------
// pwmp_out_reg
// Result register with a skid entry, so upstream ready is registered.
// ----------------------------------------------------------------------------
module pwmp_out_reg
  import pwmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  res_t         push_res,
  output logic         out_ready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,  // hs_position, data_byte, piece_index, block_begin,
                                 // block_length, bit_flags, flag_base
  output logic [3:0]   m_tuser,  // kind
  output logic         m_tlast
);

  res_t main_res;
  res_t skid_res;
  logic skid_valid;
  logic pop;

  assign out_ready = !skid_valid;
  assign pop       = m_tvalid && m_tready;

  assign m_tdata = {main_res.flag_base, main_res.bit_flags, main_res.block_length,
                    main_res.block_begin, main_res.piece_index, main_res.data_byte,
                    main_res.hs_position};
  assign m_tuser = main_res.kind;
  assign m_tlast = main_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      if (m_tvalid) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      if (m_tvalid) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end
  end

endmodule
